FILE: rtl/core/mos_pkg.sv
// Package with shared constants, types and arithmetic helpers for the scalarizer.
`default_nettype none
package mos_pkg;
    localparam int MAX_OBJECTIVES = 8;
    localparam int IDX_W = 3;
    localparam int CNT_W = 4;
    localparam int ACC_W = 48;

    localparam logic [2:0] METHOD_FIRST = 3'd0;
    localparam logic [2:0] METHOD_WSUM = 3'd1;
    localparam logic [2:0] METHOD_CHEB = 3'd2;
    localparam logic [2:0] METHOD_BI = 3'd3;
    localparam logic [2:0] METHOD_AIM = 3'd4;

    localparam logic [1:0] CFG_METHOD = 2'd0;
    localparam logic [1:0] CFG_SCALE = 2'd1;
    localparam logic [1:0] CFG_CONS = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ONE_Q16 = 48'sd65536;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    function automatic q16_t sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic acc_t sat48(input logic signed [ACC_W:0] x);
        if (x > $signed({1'b0, ACC_MAX})) begin
            return ACC_MAX;
        end else if (x < $signed({1'b1, ACC_MIN})) begin
            return ACC_MIN;
        end
        return x[ACC_W-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/mos_mul.sv
// Shared signed multiplier with floor shift by 16 and 32-bit saturation.
`default_nettype none
module mos_mul import mos_pkg::*; (
    input  wire logic                aclk,
    input  wire logic signed [32:0]  a,
    input  wire logic signed [32:0]  b,
    output logic signed [31:0]       q_sat,
    output logic signed [65:0]       p_full
);
    logic signed [65:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 66'(a) * 66'(b);
    end

    assign p_full = prod_reg;
    assign q_sat = sat32(prod_reg >>> 16);
endmodule
`default_nettype wire

FILE: rtl/core/mos_div.sv
// Restoring divider for the aim-at-target mean: magnitude by small count.
`default_nettype none
module mos_div import mos_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [ACC_W-1:0]   dividend,
    input  wire logic [CNT_W-1:0]   divisor,
    output logic                    done,
    output logic [ACC_W-1:0]        quotient
);
    logic [ACC_W-1:0] quo_reg;
    logic [CNT_W:0] rem_reg;
    logic [5:0] cnt_reg;
    logic busy_reg;
    logic [CNT_W+1:0] trial;

    assign trial = {rem_reg, quo_reg[ACC_W-1]} - {2'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'(ACC_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (!trial[CNT_W+1]) begin
                rem_reg <= trial[CNT_W:0];
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[CNT_W-1:0], quo_reg[ACC_W-1]};
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
endmodule
`default_nettype wire

FILE: rtl/core/multi_objective_scalarizer.sv
// Top level: sequencer around one shared multiplier and a serial divider.
//  channel  | ports                                  | direction
//  input    | s_valid s_ready s_op ... s_last        | in
//  result   | m_valid m_ready m_objective_value ...  | out
//  config   | cfg_we cfg_index cfg_data              | in
// A load item is written to the reference table at its accepting edge, leaving the
// sequencer idle. An evaluate item keeps s_ready low while it runs, with an issue
// and a wait state for each of up to four passes through the single shared
// multiplier. A last item adds the output state and, for aim-at-target, the divider.
// Reset is synchronous; s_ready stays low while an item is in work or a
// result waits in the output register for m_ready.
`default_nettype none
module multi_objective_scalarizer import mos_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [2:0]         cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_op,
    input  wire logic [2:0]         s_index,
    input  wire logic signed [31:0] s_value,
    input  wire logic signed [31:0] s_weight,
    input  wire logic signed [31:0] s_lower_bound,
    input  wire logic [30:0]        s_inv_span,
    input  wire logic signed [31:0] s_cons_min,
    input  wire logic signed [31:0] s_cons_max,
    input  wire logic [30:0]        s_cons_scale,
    input  wire logic               s_last,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_objective_value,
    output logic                    m_violated,
    output logic [30:0]             m_violation_sum
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_VIOL = 4'd1;
    localparam logic [3:0] ST_VWAIT = 4'd2;
    localparam logic [3:0] ST_M1 = 4'd3;
    localparam logic [3:0] ST_M1W = 4'd4;
    localparam logic [3:0] ST_M2 = 4'd5;
    localparam logic [3:0] ST_M2W = 4'd6;
    localparam logic [3:0] ST_M3 = 4'd7;
    localparam logic [3:0] ST_M3W = 4'd8;
    localparam logic [3:0] ST_ACC = 4'd9;
    localparam logic [3:0] ST_FIN = 4'd10;
    localparam logic [3:0] ST_DIV = 4'd11;
    localparam logic [3:0] ST_OUT = 4'd12;

    logic [2:0] method_reg;
    logic scale_reg, cons_reg;
    q16_t ref_mem [MAX_OBJECTIVES];
    q16_t pend_mem [MAX_OBJECTIVES];
    logic [MAX_OBJECTIVES-1:0] pmask_reg;
    acc_t acc_reg, vacc_reg;
    logic [CNT_W-1:0] cnt_reg;
    q16_t first_reg;
    logic [3:0] state_reg;

    q16_t v_reg, w_reg, lb_reg, cmin_reg, cmax_reg, r_reg, t_reg;
    logic [30:0] isp_reg, cs_reg;
    logic last_reg, active_reg;
    logic [2:0] meth_reg;

    logic signed [32:0] ma, mb;
    logic signed [31:0] mq;
    logic signed [65:0] mp;
    logic div_start, div_done;
    logic [ACC_W-1:0] div_q, div_mag;
    logic [IDX_W-1:0] k;

    mos_mul u_mul (.aclk(aclk), .a(ma), .b(mb), .q_sat(mq), .p_full(mp));
    mos_div u_div (.aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_mag),
                   .divisor(cnt_reg), .done(div_done), .quotient(div_q));

    assign k = cnt_reg[IDX_W-1:0];
    assign s_ready = (state_reg == ST_IDLE) && !m_valid;
    assign div_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
    assign div_start = (state_reg == ST_FIN) && !vacc_reg[ACC_W-1] && vacc_reg == '0
                       && method_reg == METHOD_AIM && cnt_reg != '0;

    logic vlow, vhigh;
    assign vlow = v_reg < cmin_reg;
    assign vhigh = v_reg > cmax_reg;

    always_comb begin
        ma = '0;
        mb = '0;
        case (state_reg)
            ST_VIOL: begin
                ma = vlow ? 33'(cmin_reg) - 33'(v_reg) : 33'(v_reg) - 33'(cmax_reg);
                mb = {2'b0, cs_reg};
            end
            ST_M1: begin
                if (meth_reg == METHOD_WSUM) begin
                    ma = 33'(v_reg) - 33'(lb_reg);
                    mb = {2'b0, isp_reg};
                end else if (meth_reg == METHOD_CHEB) begin
                    ma = 33'(w_reg);
                    mb = (v_reg >= r_reg) ? 33'(v_reg) - 33'(r_reg) : 33'(r_reg) - 33'(v_reg);
                end else begin
                    ma = 33'(w_reg);
                    mb = 33'(v_reg) - 33'(r_reg);
                end
            end
            ST_M2: begin
                if (meth_reg == METHOD_WSUM) begin
                    ma = 33'(w_reg);
                    mb = 33'(t_reg);
                end else begin
                    ma = 33'(t_reg);
                    mb = {2'b0, isp_reg};
                end
            end
            ST_M3: begin
                ma = 33'(t_reg);
                mb = 33'(t_reg);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg <= METHOD_FIRST;
            scale_reg <= 1'b1;
            cons_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_METHOD: method_reg <= cfg_data;
                CFG_SCALE: scale_reg <= cfg_data[0];
                CFG_CONS: cons_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            v_reg <= s_value;
            w_reg <= s_weight;
            lb_reg <= s_lower_bound;
            isp_reg <= s_inv_span;
            cmin_reg <= s_cons_min;
            cmax_reg <= s_cons_max;
            cs_reg <= s_cons_scale;
            last_reg <= s_last;
            meth_reg <= method_reg;
            r_reg <= ref_mem[k];
        end
        if (state_reg == ST_M1W || state_reg == ST_M2W) begin
            t_reg <= (state_reg == ST_M1W && meth_reg == METHOD_WSUM && !scale_reg)
                     ? v_reg : mq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_OBJECTIVES; i++) begin
                ref_mem[i] <= '0;
            end
            pmask_reg <= '0;
            acc_reg <= '0;
            vacc_reg <= '0;
            cnt_reg <= '0;
            first_reg <= '0;
            state_reg <= ST_IDLE;
            active_reg <= 1'b0;
            m_valid <= 1'b0;
            m_objective_value <= '0;
            m_violated <= 1'b0;
            m_violation_sum <= '0;
        end else begin
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        if (s_op == OP_LOAD) begin
                            ref_mem[s_index] <= s_value;
                        end else begin
                            active_reg <= cnt_reg < CNT_W'(MAX_OBJECTIVES);
                            if (cnt_reg == '0) begin
                                first_reg <= s_value;
                            end
                            state_reg <= ST_VIOL;
                        end
                    end
                end
                ST_VIOL: begin
                    state_reg <= (active_reg && cons_reg && (vlow || vhigh)) ? ST_VWAIT : ST_M1;
                end
                ST_VWAIT: begin
                    vacc_reg <= sat48((ACC_W+1)'(vacc_reg) + (ACC_W+1)'(ONE_Q16)
                                      + (ACC_W+1)'(mq));
                    state_reg <= ST_M1;
                end
                ST_M1: begin
                    if (!active_reg) begin
                        state_reg <= ST_FIN;
                    end else if (meth_reg == METHOD_WSUM || meth_reg == METHOD_CHEB
                                 || meth_reg == METHOD_AIM) begin
                        state_reg <= ST_M1W;
                    end else begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_M1W: begin
                    if (meth_reg == METHOD_WSUM) begin
                        state_reg <= ST_M2;
                    end else begin
                        state_reg <= scale_reg ? ST_M2 : (meth_reg == METHOD_AIM ? ST_M3 : ST_ACC);
                    end
                    if (meth_reg == METHOD_CHEB && ((!w_reg[31] && w_reg != '0 && v_reg < r_reg)
                                                    || (w_reg[31] && v_reg > r_reg))) begin
                        pend_mem[k] <= v_reg;
                        pmask_reg[k] <= 1'b1;
                    end
                end
                ST_M2: state_reg <= ST_M2W;
                ST_M2W: state_reg <= (meth_reg == METHOD_AIM) ? ST_M3 : ST_ACC;
                ST_M3: state_reg <= ST_M3W;
                ST_M3W: begin
                    acc_reg <= sat48((ACC_W+1)'(acc_reg) + (ACC_W+1)'(mp >>> 16));
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (meth_reg == METHOD_WSUM) begin
                        acc_reg <= sat48((ACC_W+1)'(acc_reg) + (ACC_W+1)'(t_reg));
                    end else if (meth_reg == METHOD_CHEB && ACC_W'(t_reg) >= acc_reg) begin
                        acc_reg <= ACC_W'(t_reg);
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (!last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (div_start) begin
                        state_reg <= ST_DIV;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        acc_reg <= acc_reg[ACC_W-1] ? ACC_W'(-div_q) : div_q;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    m_valid <= 1'b1;
                    m_violated <= vacc_reg > '0;
                    if (vacc_reg > '0) begin
                        m_objective_value <= '0;
                        m_violation_sum <= (vacc_reg > 48'sd2147483647) ? 31'h7FFFFFFF
                                         : vacc_reg[30:0];
                    end else begin
                        m_violation_sum <= '0;
                        case (method_reg)
                            METHOD_FIRST: m_objective_value <= first_reg;
                            METHOD_WSUM, METHOD_CHEB, METHOD_AIM:
                                m_objective_value <= (method_reg == METHOD_AIM && cnt_reg == '0)
                                    ? '0 : sat32(66'(acc_reg));
                            default: m_objective_value <= '0;
                        endcase
                        for (int i = 0; i < MAX_OBJECTIVES; i++) begin
                            if (pmask_reg[i]) begin
                                ref_mem[i] <= pend_mem[i];
                            end
                        end
                    end
                    pmask_reg <= '0;
                    acc_reg <= '0;
                    vacc_reg <= '0;
                    cnt_reg <= '0;
                    first_reg <= '0;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_violated && m_valid |-> m_objective_value == '0) else $error("value on violation");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("input taken while result waits");
endmodule
`default_nettype wire

FILE: tb/sv/multi_objective_scalarizer_tb.sv
// Self-checking testbench for the multi-objective scalarizer with a fixed-point predictor.
`timescale 1ns / 1ps

import mos_pkg::*;

class scalar_scoreboard;
    logic [2:0] method;
    logic scale_on;
    logic cons_on;
    logic signed [31:0] ref_pt [MAX_OBJECTIVES];
    logic signed [31:0] pend_pt [MAX_OBJECTIVES];
    logic [MAX_OBJECTIVES-1:0] pend_mask;
    longint acc;
    longint viol_acc;
    int count;
    logic signed [31:0] first_val;
    logic signed [31:0] exp_obj [$];
    logic exp_viol [$];
    logic [30:0] exp_vsum [$];
    int errors;

    function new();
        method = METHOD_FIRST;
        scale_on = 1'b1;
        cons_on = 1'b0;
        for (int i = 0; i < MAX_OBJECTIVES; i++) begin
            ref_pt[i] = '0;
            pend_pt[i] = '0;
        end
        errors = 0;
        clear();
    endfunction

    function void clear();
        pend_mask = '0;
        acc = 0;
        viol_acc = 0;
        count = 0;
        first_val = '0;
    endfunction

    function longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function longint clip48(longint x);
        if (x > 64'sh7FFFFFFFFFFF) return 64'sh7FFFFFFFFFFF;
        if (x < -64'sh800000000000) return -64'sh800000000000;
        return x;
    endfunction

    function longint fmul(longint a, longint b);
        longint p;
        p = a * b;
        return clip32(p >>> 16);
    endfunction

    function void note_input(logic op, logic [2:0] idx, logic signed [31:0] v,
                             logic signed [31:0] w, logic signed [31:0] lb,
                             logic [30:0] isp, logic signed [31:0] cmin,
                             logic signed [31:0] cmax, logic [30:0] cs, logic lst);
        longint vv, ww, rr, t, o;
        int k;
        if (op == OP_LOAD) begin
            ref_pt[idx] = v;
            return;
        end
        if (count < MAX_OBJECTIVES) begin
            k = count;
            vv = v;
            ww = w;
            rr = ref_pt[k];
            if (k == 0) first_val = v;
            if (cons_on) begin
                if (v < cmin)
                    viol_acc = clip48(viol_acc + 65536 + fmul(longint'(cmin) - vv, cs));
                else if (v > cmax)
                    viol_acc = clip48(viol_acc + 65536 + fmul(vv - longint'(cmax), cs));
            end
            if (method == METHOD_WSUM) begin
                t = scale_on ? fmul(vv - longint'(lb), isp) : vv;
                acc = clip48(acc + fmul(ww, t));
            end else if (method == METHOD_CHEB) begin
                t = fmul(ww, vv >= rr ? vv - rr : rr - vv);
                if (scale_on) t = fmul(t, isp);
                if (t >= acc) acc = t;
                if ((ww > 0 && vv < rr) || (ww < 0 && vv > rr)) begin
                    pend_pt[k] = v;
                    pend_mask[k] = 1'b1;
                end
            end else if (method == METHOD_AIM) begin
                t = fmul(ww, vv - rr);
                if (scale_on) t = fmul(t, isp);
                acc = clip48(acc + ((t * t) >>> 16));
            end
            count = k + 1;
        end
        if (!lst) return;
        o = 0;
        if (viol_acc > 0) begin
            exp_viol = {exp_viol, 1'b1};
            exp_vsum = {exp_vsum, (viol_acc > 64'sd2147483647 ? 31'h7FFFFFFF : viol_acc[30:0])};
        end else begin
            if (method == METHOD_FIRST) o = first_val;
            else if (method == METHOD_WSUM || method == METHOD_CHEB) o = clip32(acc);
            else if (method == METHOD_AIM && count > 0) o = clip32(acc / count);
            for (int i = 0; i < MAX_OBJECTIVES; i++)
                if (pend_mask[i]) ref_pt[i] = pend_pt[i];
            exp_viol = {exp_viol, 1'b0};
            exp_vsum = {exp_vsum, 31'd0};
        end
        exp_obj = {exp_obj, o[31:0]};
        clear();
    endfunction

    function void check_result(logic signed [31:0] obj, logic viol, logic [30:0] vsum);
        logic signed [31:0] eo;
        logic ev;
        logic [30:0] es;
        if (exp_obj.size() == 0) begin
            $error("unexpected result word: objective_value %0d", obj);
            errors++;
            return;
        end
        eo = exp_obj.pop_front();
        ev = exp_viol.pop_front();
        es = exp_vsum.pop_front();
        if (obj !== eo) begin
            $error("objective_value: expected %0d, got %0d", eo, obj);
            errors++;
        end
        if (viol !== ev) begin
            $error("violated: expected %0d, got %0d", ev, viol);
            errors++;
        end
        if (vsum !== es) begin
            $error("violation_sum: expected %0d, got %0d", es, vsum);
            errors++;
        end
    endfunction
endclass

module multi_objective_scalarizer_tb;
    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [2:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic s_op;
    logic [2:0] s_index;
    logic signed [31:0] s_value;
    logic signed [31:0] s_weight;
    logic signed [31:0] s_lower_bound;
    logic [30:0] s_inv_span;
    logic signed [31:0] s_cons_min;
    logic signed [31:0] s_cons_max;
    logic [30:0] s_cons_scale;
    logic s_last;
    logic m_valid;
    logic m_ready;
    logic signed [31:0] m_objective_value;
    logic m_violated;
    logic [30:0] m_violation_sum;

    scalar_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;

    multi_objective_scalarizer dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_result(m_objective_value, m_violated, m_violation_sum);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [2:0] data);
        s_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_METHOD) board.method = data;
        else if (idx == CFG_SCALE) board.scale_on = data[0];
        else if (idx == CFG_CONS) board.cons_on = data[0];
        @(posedge aclk);
    endtask

    task automatic send_word(logic op, logic [2:0] idx, logic signed [31:0] v,
                             logic signed [31:0] w, logic signed [31:0] lb,
                             logic [30:0] isp, logic signed [31:0] cmin,
                             logic signed [31:0] cmax, logic [30:0] cs, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_index <= idx;
        s_value <= v;
        s_weight <= w;
        s_lower_bound <= lb;
        s_inv_span <= isp;
        s_cons_min <= cmin;
        s_cons_max <= cmax;
        s_cons_scale <= cs;
        s_last <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(op, idx, v, w, lb, isp, cmin, cmax, cs, lst);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return $urandom_range(262143) - 131072;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(logic lst);
        logic signed [31:0] v, cmin, cmax;
        v = pick32();
        cmin = ($urandom_range(2) == 0) ? 32'sh80000000 : pick32();
        cmax = ($urandom_range(2) == 0) ? 32'sh7FFFFFFF : pick32();
        send_word(OP_EVAL, 3'($urandom), v, pick32(), pick32(), 31'($urandom), cmin, cmax,
                  31'($urandom), lst);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (board.exp_obj.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (80) @(posedge aclk);
    endtask

    initial begin
        int len;
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_op = 1'b0;
        s_index = '0;
        s_value = '0;
        s_weight = '0;
        s_lower_bound = '0;
        s_inv_span = '0;
        s_cons_min = '0;
        s_cons_max = '0;
        s_cons_scale = '0;
        s_last = 1'b0;
        m_ready = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: extremes, every method, overlong vector, violations.
        send_random(1'b1);
        drain();
        write_reg(CFG_METHOD, METHOD_WSUM);
        send_word(OP_EVAL, 3'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF,
                  32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF, 1'b0);
        send_word(OP_EVAL, 3'd0, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 31'd0,
                  32'sh80000000, 32'sh7FFFFFFF, 31'd0, 1'b1);
        drain();
        write_reg(CFG_METHOD, METHOD_CHEB);
        send_word(OP_LOAD, 3'd3, 32'sh00050000, '0, '0, '0, '0, '0, '0, 1'b0);
        for (int i = 0; i < 10; i++) send_random(i == 9);
        drain();
        write_reg(CFG_METHOD, METHOD_AIM);
        write_reg(CFG_SCALE, 3'd0);
        send_random(1'b0);
        send_random(1'b1);
        drain();
        write_reg(CFG_METHOD, METHOD_BI);
        write_reg(CFG_CONS, 3'd1);
        send_word(OP_EVAL, 3'd7, 32'sh80000000, 32'sd1, 32'sd2, 31'd3, 32'sh7FFFFFFF,
                  32'sh7FFFFFFF, 31'h7FFFFFFF, 1'b1);
        send_word(OP_EVAL, 3'd7, 32'sh7FFFFFFF, 32'sd1, 32'sd2, 31'd3, 32'sh80000000,
                  32'sh80000000, 31'h7FFFFFFF, 1'b1);
        drain();
        write_reg(CFG_METHOD, 3'd7);
        send_random(1'b1);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 63; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 63; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            write_reg(CFG_METHOD, (ph % 8 == 7) ? 3'($urandom_range(7)) : 3'(ph % 5));
            write_reg(CFG_SCALE, 3'($urandom_range(1)));
            write_reg(CFG_CONS, 3'($urandom_range(3) == 0));
            for (int j = 0; j < 100; j++) begin
                if ($urandom_range(7) == 0) begin
                    send_word(OP_LOAD, 3'($urandom), pick32(), pick32(), pick32(),
                              31'($urandom), pick32(), pick32(), 31'($urandom),
                              1'($urandom));
                end else begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(12, 9)
                                                   : $urandom_range(1, 8);
                    for (int e = 0; e < len; e++) send_random(e == len - 1);
                    j += len - 1;
                end
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (board.errors == 0 && board.exp_obj.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

FILE: multi_objective_scalarizer.f
rtl/core/mos_pkg.sv
rtl/core/mos_mul.sv
rtl/core/mos_div.sv
rtl/core/multi_objective_scalarizer.sv
tb/sv/multi_objective_scalarizer_tb.sv
